>>> hdl/lbrh_pkg.sv
`timescale 1ns / 1ps

package lbrh_pkg;

    // Per-beat control for one histogram bank.
    // issue: an item enters this cycle, read the addressed entry.
    // bump:  the item is a counted sample, increment that entry next cycle.
    typedef struct packed {
        logic issue;
        logic bump;
    } bank_ctl_t;

endpackage

>>> hdl/lbrh_bank.sv
`timescale 1ns / 1ps

module lbrh_bank
    import lbrh_pkg::*;
#(
    parameter int DEPTH       = 17,
    parameter int COUNT_WIDTH = 32,
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bank_ctl_t              ctl,
    input  logic [AW-1:0]          addr,
    output logic [COUNT_WIDTH-1:0] count
);

    logic [COUNT_WIDTH-1:0] mem [DEPTH];

    logic [DEPTH-1:0]       entry_valid_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic [COUNT_WIDTH-1:0] wr_data_reg;
    logic [COUNT_WIDTH-1:0] bumped;
    logic [AW-1:0]          addr_reg;
    logic                   bump_reg;
    logic                   valid_rd_reg;
    logic                   fwd_hit_reg;

    // read-before-write memory, one read and one write port
    always_ff @(posedge aclk) begin
        if (bump_reg) begin
            mem[addr_reg] <= bumped;
        end
        if (ctl.issue) begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bump_reg        <= 1'b0;
            entry_valid_reg <= '0;
        end else begin
            bump_reg <= ctl.issue & ctl.bump;
            if (bump_reg) begin
                entry_valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.issue) begin
            addr_reg     <= addr;
            valid_rd_reg <= entry_valid_reg[addr];
            // write landing on the same edge as this read: memory returns stale data
            fwd_hit_reg  <= bump_reg && (addr_reg == addr);
        end
        if (bump_reg) begin
            wr_data_reg <= bumped;
        end
    end

    always_comb begin
        if (fwd_hit_reg) begin
            count = wr_data_reg;
        end else if (valid_rd_reg) begin
            count = rd_data_reg;
        end else begin
            count = '0;
        end
    end

    // saturating increment
    assign bumped = (&count) ? count : count + 1'b1;

endmodule

>>> hdl/log_binned_residual_histograms.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake          Payload
// s_       in   s_valid / s_ready  s_mode, s_obs_value, s_pred_value, s_like_value,
//                                  s_which_histogram, s_read_bin
// m_       out  m_valid / m_ready  m_bin_count, m_bin_number
//
// One beat per cycle while s_ready is high. Cycle of acceptance: bin select and bank
// read; next cycle: saturating increment written back, or the read count handed to a
// two-entry output queue. A write followed at once by a read of the same entry is forwarded.
// Reset (aresetn, synchronous) clears per-entry valid bits, so all counts read zero.
// s_ready drops when the output queue, counting a read in flight, has no room left.

module log_binned_residual_histograms
    import lbrh_pkg::*;
#(
    parameter int LIKE_BINS   = 22,
    parameter int VALUE_BINS  = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [31:0] s_obs_value,
    input  logic [31:0] s_pred_value,
    input  logic [31:0] s_like_value,
    input  logic [1:0]  s_which_histogram,
    input  logic [4:0]  s_read_bin,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_bin_count,
    output logic [4:0]  m_bin_number
);

    typedef enum logic [1:0] {
        HIST_LIKE = 2'd0,
        HIST_OBS  = 2'd1,
        HIST_PRED = 2'd2,
        HIST_RES  = 2'd3
    } hist_sel_t;

    localparam logic MODE_READ = 1'b1;

    localparam int LIKE_DEPTH = LIKE_BINS + 1;
    localparam int OBS_DEPTH  = VALUE_BINS + 1;
    localparam int RES_DEPTH  = 2 * VALUE_BINS;
    localparam int LIKE_AW    = $clog2(LIKE_DEPTH);
    localparam int OBS_AW     = $clog2(OBS_DEPTH);
    localparam int RES_AW     = $clog2(RES_DEPTH);
    // Q16.16: 2^-6 is 1 << 10, 0.125 is 1 << 13
    localparam int LIKE_SHIFT = 10;
    localparam int OBS_SHIFT  = 12;

    function automatic logic [63:0] obs_edge(input int k);
        logic [63:0] e;
        e = (k == 0) ? 64'd0 : (64'd1 << (OBS_SHIFT + k));
        return e;
    endfunction

    function automatic logic [LIKE_AW-1:0] like_bin(input logic [31:0] v);
        logic [LIKE_AW-1:0] b;
        b = LIKE_AW'(LIKE_BINS);
        for (int i = LIKE_BINS - 1; i >= 0; i--) begin
            if ({32'd0, v} <= (64'd1 << (LIKE_SHIFT + i))) begin
                b = LIKE_AW'(i);
            end
        end
        return b;
    endfunction

    function automatic logic [OBS_AW-1:0] obs_bin(input logic [31:0] v);
        logic [OBS_AW-1:0] b;
        b = OBS_AW'(VALUE_BINS);
        for (int i = VALUE_BINS - 1; i >= 0; i--) begin
            if ({32'd0, v} <= obs_edge(i)) begin
                b = OBS_AW'(i);
            end
        end
        return b;
    endfunction

    function automatic logic [RES_AW-1:0] res_bin(input logic signed [32:0] r);
        logic [RES_AW-1:0]  b;
        logic signed [63:0] rw;
        logic signed [63:0] e;
        b  = RES_AW'(RES_DEPTH - 1);
        rw = 64'(r);
        for (int i = RES_DEPTH - 2; i >= 0; i--) begin
            if (i < VALUE_BINS - 1) begin
                e = -$signed(obs_edge(VALUE_BINS - 1 - i));
            end else begin
                e = $signed(obs_edge(i - (VALUE_BINS - 1)));
            end
            if (rw <= e) begin
                b = RES_AW'(i);
            end
        end
        return b;
    endfunction

    // ---------------- acceptance stage ----------------
    logic               accept;
    logic               is_read;
    logic               counted;
    logic signed [32:0] resid;
    logic               like_in_range, obs_in_range, res_in_range;
    logic [LIKE_AW-1:0] like_addr;
    logic [OBS_AW-1:0]  obs_addr, pred_addr;
    logic [RES_AW-1:0]  res_addr;
    bank_ctl_t          bank_ctl;

    assign accept  = s_valid && s_ready;
    assign is_read = (s_mode == MODE_READ);
    assign counted = !is_read && (s_pred_value != 32'd0);
    assign resid   = $signed({1'b0, s_obs_value}) - $signed({1'b0, s_pred_value});

    assign like_in_range = 32'(s_read_bin) < LIKE_DEPTH;
    assign obs_in_range  = 32'(s_read_bin) < OBS_DEPTH;
    assign res_in_range  = 32'(s_read_bin) < RES_DEPTH;

    always_comb begin
        if (is_read) begin
            like_addr = like_in_range ? LIKE_AW'(s_read_bin) : '0;
            obs_addr  = obs_in_range ? OBS_AW'(s_read_bin) : '0;
            pred_addr = obs_in_range ? OBS_AW'(s_read_bin) : '0;
            res_addr  = res_in_range ? RES_AW'(s_read_bin) : '0;
        end else begin
            like_addr = like_bin(s_like_value);
            obs_addr  = obs_bin(s_obs_value);
            pred_addr = obs_bin(s_pred_value);
            res_addr  = res_bin(resid);
        end
    end

    assign bank_ctl.issue = accept;
    assign bank_ctl.bump  = counted;

    logic [COUNT_WIDTH-1:0] like_count, seen_count, fcst_count, res_count;

    lbrh_bank #(.DEPTH(LIKE_DEPTH), .COUNT_WIDTH(COUNT_WIDTH)) u_like_bank (
        .aclk(aclk), .aresetn(aresetn), .ctl(bank_ctl), .addr(like_addr), .count(like_count)
    );

    lbrh_bank #(.DEPTH(OBS_DEPTH), .COUNT_WIDTH(COUNT_WIDTH)) u_obs_bank (
        .aclk(aclk), .aresetn(aresetn), .ctl(bank_ctl), .addr(obs_addr), .count(seen_count)
    );

    lbrh_bank #(.DEPTH(OBS_DEPTH), .COUNT_WIDTH(COUNT_WIDTH)) u_pred_bank (
        .aclk(aclk), .aresetn(aresetn), .ctl(bank_ctl), .addr(pred_addr), .count(fcst_count)
    );

    lbrh_bank #(.DEPTH(RES_DEPTH), .COUNT_WIDTH(COUNT_WIDTH)) u_res_bank (
        .aclk(aclk), .aresetn(aresetn), .ctl(bank_ctl), .addr(res_addr), .count(res_count)
    );

    // ---------------- second stage: read result ----------------
    logic      s2_read_reg;
    hist_sel_t s2_which_reg;
    logic [4:0] s2_bin_reg;
    logic      s2_in_range_reg;
    logic      s2_in_range_next;
    logic [COUNT_WIDTH-1:0] sel_count;
    logic [63:0] sel_wide;
    logic [31:0] res_bin_count;

    always_comb begin
        unique case (hist_sel_t'(s_which_histogram))
            HIST_LIKE: s2_in_range_next = like_in_range;
            HIST_OBS:  s2_in_range_next = obs_in_range;
            HIST_PRED: s2_in_range_next = obs_in_range;
            HIST_RES:  s2_in_range_next = res_in_range;
            default:   s2_in_range_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_read_reg <= 1'b0;
        end else begin
            s2_read_reg <= accept && is_read;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s2_which_reg    <= hist_sel_t'(s_which_histogram);
            s2_bin_reg      <= s_read_bin;
            s2_in_range_reg <= s2_in_range_next;
        end
    end

    always_comb begin
        unique case (s2_which_reg)
            HIST_LIKE: sel_count = like_count;
            HIST_OBS:  sel_count = seen_count;
            HIST_PRED: sel_count = fcst_count;
            HIST_RES:  sel_count = res_count;
            default:   sel_count = '0;
        endcase
    end

    assign sel_wide      = 64'(sel_count);
    assign res_bin_count = s2_in_range_reg ? sel_wide[31:0] : 32'd0;

    // ---------------- two-entry output queue ----------------
    logic [1:0]  out_count_reg;
    logic [31:0] q_count0_reg, q_count1_reg;
    logic [4:0]  q_bin0_reg, q_bin1_reg;
    logic        pop;
    logic [1:0]  occ;
    logic [1:0]  wr_pos;

    assign m_valid      = (out_count_reg != 2'd0);
    assign m_bin_count  = q_count0_reg;
    assign m_bin_number = q_bin0_reg;
    assign pop          = m_valid && m_ready;

    // room must remain for a read beat accepted this cycle
    assign occ     = out_count_reg + {1'b0, s2_read_reg} - {1'b0, pop};
    assign s_ready = (occ <= 2'd1);
    assign wr_pos  = out_count_reg - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_count_reg <= 2'd0;
        end else begin
            out_count_reg <= occ;
        end
    end

    // a read landing in the head slot wins over the shift from slot 1
    always_ff @(posedge aclk) begin
        if (s2_read_reg && (wr_pos == 2'd0)) begin
            q_count0_reg <= res_bin_count;
            q_bin0_reg   <= s2_bin_reg;
        end else if (pop) begin
            q_count0_reg <= q_count1_reg;
            q_bin0_reg   <= q_bin1_reg;
        end
        if (s2_read_reg && (wr_pos != 2'd0)) begin
            q_count1_reg <= res_bin_count;
            q_bin1_reg   <= s2_bin_reg;
        end
    end

endmodule
